// File: hdl/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// Shared constants, curve decode map and Q2.30 helpers for the easing curve
// evaluator.
// ----------------------------------------------------------------------------
package ece_pkg;

	localparam int QB = 30;
	localparam logic [31:0] Q_ONE  = 32'h4000_0000;
	localparam logic [31:0] Q_HALF = 32'h2000_0000;
	localparam logic [31:0] Q_LN2  = 32'd744261118;
	localparam logic [31:0] SC1    = 32'd1686629713;
	localparam logic [31:0] SC3    = 32'd693598668;
	localparam logic [31:0] SC5    = 32'd85569306;
	localparam logic [31:0] SC7    = 32'd5026995;
	localparam logic [31:0] SC9    = 32'd172272;

	// accept edge to result strobe, in clock cycles
	localparam int PIPE_DEPTH = 42;

	typedef enum logic [3:0] {
		FAM_LIN,
		FAM_QUAD,
		FAM_CUBIC,
		FAM_QUART,
		FAM_QUINT,
		FAM_SINE,
		FAM_CIRC,
		FAM_EXPO,
		FAM_NONE
	} fam_t;

	typedef enum logic [1:0] {
		KIND_IN,
		KIND_OUT,
		KIND_INOUT
	} kind_t;

	typedef struct packed {
		fam_t  fam;
		kind_t kind;
	} curve_dec_t;

	localparam curve_dec_t CURVE_MAP [32] = '{
		0:  '{FAM_LIN,   KIND_IN},
		1:  '{FAM_QUAD,  KIND_IN},
		2:  '{FAM_QUAD,  KIND_OUT},
		3:  '{FAM_QUAD,  KIND_INOUT},
		4:  '{FAM_CUBIC, KIND_IN},
		5:  '{FAM_CUBIC, KIND_OUT},
		6:  '{FAM_CUBIC, KIND_INOUT},
		7:  '{FAM_QUART, KIND_IN},
		8:  '{FAM_QUART, KIND_OUT},
		9:  '{FAM_QUART, KIND_INOUT},
		10: '{FAM_QUINT, KIND_IN},
		11: '{FAM_QUINT, KIND_OUT},
		12: '{FAM_QUINT, KIND_INOUT},
		13: '{FAM_SINE,  KIND_IN},
		14: '{FAM_SINE,  KIND_OUT},
		15: '{FAM_SINE,  KIND_INOUT},
		16: '{FAM_CIRC,  KIND_IN},
		17: '{FAM_CIRC,  KIND_OUT},
		18: '{FAM_CIRC,  KIND_INOUT},
		19: '{FAM_EXPO,  KIND_IN},
		20: '{FAM_EXPO,  KIND_OUT},
		21: '{FAM_EXPO,  KIND_INOUT},
		default: '{FAM_NONE, KIND_IN}
	};

	typedef struct packed {
		logic  valid;
		fam_t  fam;
		kind_t kind;
		logic  lo;
		logic  tz;
		logic  tone;
	} ctx_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [30:0] root;
	} sq_t;

	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		logic [64:0] sum;
		prod = 64'(a) * 64'(b);
		sum  = {1'b0, prod} + 65'(Q_HALF);
		return sum[61:30];
	endfunction

	function automatic logic [35:0] one_minus(input logic [35:0] x);
		return (x >= 36'(Q_ONE)) ? 36'd0 : 36'(Q_ONE) - x;
	endfunction

endpackage

// File: hdl/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Pipelined easing curve evaluator: one Q1.15 time sample in, one eased
// Q1.15 position out, curve chosen by the curve register.
// ----------------------------------------------------------------------------
//
//  channel   signals                       transfer
//  -------   ----------------------------  --------------------------------
//  input     start, busy, time_norm        start high and busy low at edge
//  result    done, eased_pos               done high for one cycle
//  config    curve_we, curve_wdata         curve_we high at edge
//
//  One word enters per clock; busy stays low. Each result leaves with its
//  done strobe. The pipeline length is set by the twelve-term exponential
//  series, three stages per term (multiply, reciprocal multiply,
//  correction).
//  All families run side by side and the curve picks one at the end.
//  Reset clears the valid bits and sets the curve to linear.
//  The receiver cannot stall: results leave on the strobe.
//
module easing_curve_evaluator
	import ece_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] time_norm,
	input  logic        curve_we,
	input  logic [4:0]  curve_wdata,
	output logic        done,
	output logic [15:0] eased_pos
);

	localparam int SH = QB - FRAC_BITS;
	localparam logic [30:0] ONE_IN   = 31'(1) << FRAC_BITS;
	localparam logic [31:0] RND_HALF = (32'(1) << SH) >> 1;
	localparam int S_COMB = PIPE_DEPTH - 1;
	localparam int S_RAW  = PIPE_DEPTH - 2;
	localparam logic [64:0] Q32 = 65'd1 << 32;
	localparam logic [32:0] RECIP [12] = '{
		33'(Q32 / 12), 33'(Q32 / 11), 33'(Q32 / 10), 33'(Q32 / 9),
		33'(Q32 / 8),  33'(Q32 / 7),  33'(Q32 / 6),  33'(Q32 / 5),
		33'(Q32 / 4),  33'(Q32 / 3),  33'(Q32 / 2),  33'(Q32 / 1)
	};
	localparam logic [3:0] DIVK [12] = '{
		4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
	};
	localparam logic [31:0] SCOEF [4:7] = '{SC7, SC5, SC3, SC1};
	localparam fam_t POLY_FAM [4:6] = '{FAM_CUBIC, FAM_QUART, FAM_QUINT};

	function automatic sq_t sq_steps(input logic [30:0] a, input sq_t cur, input int j0);
		logic [61:0] rad;
		logic [34:0] trial;
		sq_t nx;
		rad = {1'b0, a, 30'd0};
		nx  = cur;
		for (int j = 0; j < 4; j++) begin
			if (j0 + j <= 30) begin
				nx.rem = {nx.rem[32:0], rad[61 - 2 * (j0 + j) -: 2]};
				trial  = {2'b00, nx.root, 2'b01};
				if (nx.rem >= trial) begin
					nx.rem  = nx.rem - trial;
					nx.root = {nx.root[29:0], 1'b1};
				end else begin
					nx.root = {nx.root[29:0], 1'b0};
				end
			end
		end
		return nx;
	endfunction

	function automatic logic [31:0] div_fix(input logic [31:0] m, input logic [31:0] q0,
		input logic [3:0] k);
		logic [35:0] r;
		r = 36'(m) - 36'(q0) * 36'(k);
		return (r >= 36'(k)) ? q0 + 32'd1 : q0;
	endfunction

	logic [4:0]  curve_q;
	logic [30:0] t_sat;
	logic [31:0] t_in30;
	ctx_t        ctx_in;
	ctx_t        ctx_s [1:S_COMB];

	logic [31:0] t_s1;
	logic [31:0] u_c, t2_c, px_c, sx_c;
	logic [34:0] ey_c;
	logic [31:0] px_s [2:5];
	logic [31:0] sx_s [2:7];
	logic [34:0] ey_s2;
	logic [31:0] pw_s [3:5];
	logic [31:0] psel_s [3:S_RAW];
	logic [31:0] sx2_s [3:6];
	logic [31:0] sp_s [4:7];
	logic [31:0] sn_s [8:S_RAW];
	logic [35:0] ca_c;
	logic [30:0] sq_a [4:11];
	sq_t         sq_s [4:12];
	logic [30:0] rt_s [13:S_RAW];
	logic [31:0] ez_s [3:36];
	logic [3:0]  en_s [3:39];
	logic [31:0] ex_ma [12];
	logic [31:0] ex_mb [12];
	logic [31:0] ex_q0 [12];
	logic [31:0] ex_e [12];
	logic [32:0] ee_sum;
	logic [31:0] ee_s40;
	logic [35:0] v_c, pv_c;
	logic [30:0] v_s41;
	logic [31:0] r_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= '0;
		end else if (curve_we) begin
			curve_q <= curve_wdata;
		end
	end

	always_comb begin
		t_sat  = ({15'd0, time_norm} > ONE_IN) ? ONE_IN : {15'd0, time_norm};
		t_in30 = 32'(t_sat) << SH;
		ctx_in.valid = start && !busy;
		ctx_in.fam   = CURVE_MAP[curve_q].fam;
		ctx_in.kind  = CURVE_MAP[curve_q].kind;
		ctx_in.lo    = t_in30 < Q_HALF;
		ctx_in.tz    = time_norm == 16'd0;
		ctx_in.tone  = t_in30 == Q_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= S_COMB; i++) ctx_s[i] <= '0;
			done <= 1'b0;
		end else begin
			ctx_s[1] <= ctx_in;
			for (int i = 2; i <= S_COMB; i++) ctx_s[i] <= ctx_s[i - 1];
			done <= ctx_s[S_COMB].valid;
		end
	end

	always_comb begin
		u_c  = Q_ONE - t_s1;
		t2_c = t_s1 << 1;
		case (ctx_s[1].kind)
			KIND_IN: begin
				px_c = t_s1;
				sx_c = u_c;
			end
			KIND_OUT: begin
				px_c = u_c;
				sx_c = t_s1;
			end
			default: begin
				px_c = ctx_s[1].lo ? t_s1 : u_c;
				sx_c = ctx_s[1].lo ? Q_ONE - t2_c : t2_c - Q_ONE;
			end
		endcase
		ey_c = (35'(sx_c) << 3) + (35'(sx_c) << 1)
			+ ((ctx_s[1].kind == KIND_INOUT) ? 35'(Q_ONE) : 35'd0);
	end

	always_comb begin
		ca_c = one_minus((ctx_s[3].kind == KIND_INOUT) ? (36'(pw_s[3]) << 2)
			: 36'(pw_s[3]));
	end

	always_ff @(posedge clk) begin
		t_s1     <= t_in30;
		px_s[2]  <= px_c;
		sx_s[2]  <= sx_c;
		ey_s2    <= ey_c;

		pw_s[3]   <= qmul(px_s[2], px_s[2]);
		psel_s[3] <= (ctx_s[2].fam == FAM_LIN) ? px_s[2] : qmul(px_s[2], px_s[2]);
		px_s[3]   <= px_s[2];
		for (int s = 4; s <= 5; s++) pw_s[s] <= qmul(pw_s[s - 1], px_s[s - 1]);
		for (int s = 4; s <= 6; s++) begin
			psel_s[s] <= (ctx_s[s - 1].fam == POLY_FAM[s]) ? qmul(pw_s[s - 1], px_s[s - 1])
				: psel_s[s - 1];
		end
		for (int s = 4; s <= 5; s++) px_s[s] <= px_s[s - 1];
		for (int s = 7; s <= S_RAW; s++) psel_s[s] <= psel_s[s - 1];

		sx2_s[3] <= qmul(sx_s[2], sx_s[2]);
		for (int s = 3; s <= 7; s++) sx_s[s] <= sx_s[s - 1];
		for (int s = 4; s <= 6; s++) sx2_s[s] <= sx2_s[s - 1];
		sp_s[4] <= SCOEF[4] - qmul(sx2_s[3], SC9);
		for (int s = 5; s <= 7; s++) sp_s[s] <= SCOEF[s] - qmul(sx2_s[s - 1], sp_s[s - 1]);
		sn_s[8] <= qmul(sx_s[7], sp_s[7]);
		for (int s = 9; s <= S_RAW; s++) sn_s[s] <= sn_s[s - 1];

		sq_a[4] <= ca_c[30:0];
		sq_s[4] <= '0;
		for (int s = 5; s <= 12; s++) sq_s[s] <= sq_steps(sq_a[s - 1], sq_s[s - 1], 4 * (s - 5));
		for (int s = 5; s <= 11; s++) sq_a[s] <= sq_a[s - 1];
		rt_s[13] <= sq_s[12].root;
		for (int s = 14; s <= S_RAW; s++) rt_s[s] <= rt_s[s - 1];

		ez_s[3] <= qmul(Q_ONE - {2'b00, ey_s2[29:0]}, Q_LN2);
		en_s[3] <= ey_s2[33:30];
		for (int s = 4; s <= 36; s++) ez_s[s] <= ez_s[s - 1];
		for (int s = 4; s <= 39; s++) en_s[s] <= en_s[s - 1];
		for (int i = 0; i < 12; i++) begin
			ex_ma[i] <= qmul(ez_s[3 + 3 * i], (i == 0) ? Q_ONE : ex_e[(i == 0) ? 0 : i - 1]);
			ex_q0[i] <= 32'((65'(ex_ma[i]) * 65'(RECIP[i])) >> 32);
			ex_mb[i] <= ex_ma[i];
			ex_e[i]  <= Q_ONE + div_fix(ex_mb[i], ex_q0[i], DIVK[i]);
		end
		ee_s40 <= 32'(ee_sum >> (5'(en_s[39]) + 5'd1));

		v_s41     <= (v_c > 36'(Q_ONE)) ? Q_ONE[30:0] : v_c[30:0];
		eased_pos <= (r_c > 32'h0000_FFFF) ? 16'hFFFF : r_c[15:0];
	end

	assign ee_sum = 33'(ex_e[11]) + (33'd1 << en_s[39]);

	always_comb begin
		case (ctx_s[S_RAW].fam)
			FAM_QUAD:  pv_c = 36'(psel_s[S_RAW]) << 1;
			FAM_CUBIC: pv_c = 36'(psel_s[S_RAW]) << 2;
			FAM_QUART: pv_c = 36'(psel_s[S_RAW]) << 3;
			default:   pv_c = 36'(psel_s[S_RAW]) << 4;
		endcase
		case (ctx_s[S_RAW].fam)
			FAM_LIN: v_c = 36'(psel_s[S_RAW]);
			FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: begin
				case (ctx_s[S_RAW].kind)
					KIND_IN:  v_c = 36'(psel_s[S_RAW]);
					KIND_OUT: v_c = one_minus(36'(psel_s[S_RAW]));
					default:  v_c = ctx_s[S_RAW].lo ? pv_c : one_minus(pv_c);
				endcase
			end
			FAM_SINE: begin
				case (ctx_s[S_RAW].kind)
					KIND_IN:  v_c = one_minus(36'(sn_s[S_RAW]));
					KIND_OUT: v_c = 36'(sn_s[S_RAW]);
					default:  v_c = ctx_s[S_RAW].lo ? one_minus(36'(sn_s[S_RAW])) >> 1
						: (36'(Q_ONE) + 36'(sn_s[S_RAW])) >> 1;
				endcase
			end
			FAM_CIRC: begin
				case (ctx_s[S_RAW].kind)
					KIND_IN:  v_c = one_minus(36'(rt_s[S_RAW]));
					KIND_OUT: v_c = 36'(rt_s[S_RAW]);
					default:  v_c = ctx_s[S_RAW].lo ? one_minus(36'(rt_s[S_RAW])) >> 1
						: (36'(Q_ONE) + 36'(rt_s[S_RAW])) >> 1;
				endcase
			end
			FAM_EXPO: begin
				case (ctx_s[S_RAW].kind)
					KIND_IN:  v_c = ctx_s[S_RAW].tz ? 36'd0 : 36'(ee_s40);
					KIND_OUT: v_c = ctx_s[S_RAW].tone ? 36'(Q_ONE) : one_minus(36'(ee_s40));
					default: begin
						if (ctx_s[S_RAW].tz) v_c = 36'd0;
						else if (ctx_s[S_RAW].tone) v_c = 36'(Q_ONE);
						else if (ctx_s[S_RAW].lo) v_c = 36'(ee_s40);
						else v_c = one_minus(36'(ee_s40));
					end
				endcase
			end
			default: v_c = 36'd0;
		endcase
	end

	assign r_c = (32'(v_s41) + RND_HALF) >> SH;

endmodule

// File: hdl/ece_chk.sv
// ----------------------------------------------------------------------------
// ece_chk
// Port-level checks for the easing curve evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module ece_chk
	import ece_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] time_norm,
	input logic        done,
	input logic [15:0] eased_pos
);

	localparam logic [15:0] MAXV = (FRAC_BITS >= 16) ? 16'hFFFF : 16'(32'd1 << FRAC_BITS);

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without an accepted word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (eased_pos <= MAXV))
		else $error("eased position above one");

	a_time_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown(time_norm))
		else $error("accepted time sample has unknown bits");

endmodule

bind easing_curve_evaluator ece_chk #(.FRAC_BITS(FRAC_BITS)) u_ece_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.time_norm (time_norm),
	.done      (done),
	.eased_pos (eased_pos)
);
